// ----- hdl/oale_pkg.sv -----
// Shared types, codes and defaults for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_INS   = 3'd2;
    localparam logic [2:0] ST_DEL_EMPTY = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] found_position;
        logic [4:0] entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_INSERT,
        S_DELETE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       step;
        logic       finish;
        logic       emit;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       ins_bad;
        logic       del_bad;
        logic       more;
        logic       lag_vld;
        logic       hit;
    } sts_t;

endpackage

// ----- hdl/oale_datapath.sv -----
// Datapath: element store, held count, walk pointer and result registers.
`timescale 1ns / 1ps

module oale_datapath import oale_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  req_t s_data,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = (CW > 8) ? CW : 8;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rd_data_reg;
    req_t          req_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] lag_reg, lag_next;
    logic          lag_vld_reg, lag_vld_next;
    logic [2:0]    res_status_reg;
    logic [3:0]    res_pos_reg;
    rsp_t          m_data_reg;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pos_x;
    logic [CW-1:0] rd_ptr;
    logic [CW-1:0] w_adv;
    logic [AW-1:0] rd_addr;
    logic          more;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          fin_ok;

    assign cnt_x  = XW'(count_reg);
    assign pos_x  = XW'(req_reg.position);
    assign fin_ok = cmd.finish && (cmd.status == ST_OK);

    always_comb begin
        more   = 1'b0;
        rd_ptr = w_reg;
        w_adv  = w_reg;
        case (req_reg.op)
            OP_FIND: begin
                more   = (w_reg < count_reg);
                rd_ptr = w_reg;
                w_adv  = w_reg + 1'b1;
            end
            OP_INSERT: begin
                more   = (XW'(w_reg) > pos_x);
                rd_ptr = w_reg - 1'b1;
                w_adv  = (w_reg != '0) ? (w_reg - 1'b1) : w_reg;
            end
            OP_DELETE: begin
                more   = ((w_reg + 1'b1) < count_reg);
                rd_ptr = w_reg + 1'b1;
                w_adv  = w_reg + 1'b1;
            end
            default: begin
                more   = 1'b0;
            end
        endcase
    end

    assign rd_addr = rd_ptr[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = lag_reg[AW-1:0];
        wr_data = rd_data_reg;
        if (cmd.step && lag_vld_reg && (req_reg.op != OP_FIND)) begin
            wr_en = 1'b1;
        end
        if (fin_ok && (req_reg.op == OP_INSERT)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(req_reg.position);
            wr_data = $unsigned(req_reg.value);
        end
        if (fin_ok && (req_reg.op == OP_DELETE) && lag_vld_reg) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        count_next   = count_reg;
        w_next       = w_reg;
        lag_next     = lag_reg;
        lag_vld_next = lag_vld_reg;
        if (cmd.init) begin
            lag_vld_next = 1'b0;
            case (req_reg.op)
                OP_INSERT: w_next = count_reg;
                OP_DELETE: w_next = CW'(req_reg.position);
                default:   w_next = '0;
            endcase
        end
        if (cmd.step) begin
            w_next       = w_adv;
            lag_next     = w_reg;
            lag_vld_next = more;
        end
        if (fin_ok && (req_reg.op == OP_INSERT)) begin
            count_next = count_reg + 1'b1;
        end
        if (fin_ok && (req_reg.op == OP_DELETE)) begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.finish) begin
            lag_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            lag_vld_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            lag_vld_reg <= lag_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        lag_reg <= lag_next;
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (cmd.finish) begin
            res_status_reg <= cmd.status;
            res_pos_reg    <= (fin_ok && (req_reg.op == OP_FIND)) ? 4'(lag_reg) : 4'd0;
        end
        if (cmd.emit) begin
            m_data_reg.status         <= res_status_reg;
            m_data_reg.found_position <= res_pos_reg;
            m_data_reg.entry_count    <= 5'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign sts.op      = req_reg.op;
    assign sts.full    = (count_reg >= CW'(CAPACITY));
    assign sts.ins_bad = (pos_x > cnt_x);
    assign sts.del_bad = (pos_x >= cnt_x);
    assign sts.more    = more;
    assign sts.lag_vld = lag_vld_reg;
    assign sts.hit     = lag_vld_reg && (rd_data_reg == $unsigned(req_reg.value));
    assign m_data      = m_data_reg;

endmodule

// ----- hdl/oale_ctrl.sv -----
// Controller: request sequencing state machine and channel handshakes.
`timescale 1ns / 1ps

module oale_ctrl import oale_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.status   = ST_OK;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                case (sts.op)
                    OP_FIND: begin
                        cmd.init   = 1'b1;
                        state_next = S_FIND;
                    end
                    OP_INSERT: begin
                        if (sts.full) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_FULL;
                            state_next = S_RESP;
                        end else if (sts.ins_bad) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_BAD_INS;
                            state_next = S_RESP;
                        end else begin
                            cmd.init   = 1'b1;
                            state_next = S_INSERT;
                        end
                    end
                    OP_DELETE: begin
                        if (sts.del_bad) begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_DEL_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            cmd.init   = 1'b1;
                            state_next = S_DELETE;
                        end
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_FIND: begin
                if (sts.hit) begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end else if (!sts.more) begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NOT_FOUND;
                    state_next = S_RESP;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_INSERT: begin
                if (!sts.more && !sts.lag_vld) begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DELETE: begin
                if (!sts.more) begin
                    cmd.finish = 1'b1;
                    state_next = S_RESP;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hdl/ordered_array_list_engine_unit.sv -----
// Top level of the ordered array list engine: controller plus datapath.
// One request at a time; s_ready is high only while idle.
// Find compares entries from the head until a hit or the end; insert shifts the entries
// at and above position up a slot; delete shifts those above it down; rejects do not walk.
// Next request waits for the emit; the store walk (one read, one write port) sets the pace.
// Reset clears the held count and handshake state; store contents are not cleared.
`timescale 1ns / 1ps

module ordered_array_list_engine_unit import oale_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    cmd_t cmd;
    sts_t sts;

    oale_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in progress");

    a_pos_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |-> (m_data.found_position == 4'd0))
        else $error("found position set on a failed request");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (m_valid && s_ready))
        else $error("result word not presented after emit");

endmodule
